>>> hw/rtl/b91_pkg.sv
package b91_pkg;

  // Alphabet size and the reciprocal used to divide by it
  localparam int unsigned B91_RADIX       = 91;
  localparam int unsigned B91_RECIP       = 11523;  // ceil(2^20 / 91), exact for 14-bit values
  localparam int unsigned B91_RECIP_SHIFT = 20;

  // Low 13-bit group values at or below this take a 14-bit group instead
  localparam int unsigned B91_WIDE_MAX    = 88;

  // Bit queue geometry
  localparam int unsigned B91_QW   = 13;  // held bits
  localparam int unsigned B91_CW   = 4;   // bit count
  localparam int unsigned B91_GW   = 14;  // widest group
  localparam int unsigned B91_SUMW = 21;  // held bits plus one byte

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } b91_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic       message_done;
  } b91_out_t;

  // One unit of work for the back end: a group pair and/or a flush
  typedef struct packed {
    logic              grp_vld;
    logic [B91_GW-1:0] grp_val;
    logic              fl_vld;
    logic [B91_QW-1:0] fl_val;
    logic              fl_two;
    logic              eom;
  } b91_job_t;

  // Map an alphabet index to its ASCII code
  function automatic logic [7:0] b91_char(input logic [6:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    if (idx < 7'd26) begin
      ch = 8'd65 + {1'b0, idx};
    end else if (idx < 7'd52) begin
      ch = 8'd97 + {1'b0, idx - 7'd26};
    end else if (idx < 7'd62) begin
      ch = 8'd48 + {1'b0, idx - 7'd52};
    end else begin
      case (idx)
        7'd62:   ch = 8'd33;   // !
        7'd63:   ch = 8'd35;   // #
        7'd64:   ch = 8'd36;   // $
        7'd65:   ch = 8'd37;   // %
        7'd66:   ch = 8'd38;   // &
        7'd67:   ch = 8'd40;   // (
        7'd68:   ch = 8'd41;   // )
        7'd69:   ch = 8'd42;   // *
        7'd70:   ch = 8'd43;   // +
        7'd71:   ch = 8'd44;   // ,
        7'd72:   ch = 8'd46;   // .
        7'd73:   ch = 8'd47;   // /
        7'd74:   ch = 8'd58;   // :
        7'd75:   ch = 8'd59;   // ;
        7'd76:   ch = 8'd60;   // <
        7'd77:   ch = 8'd61;   // =
        7'd78:   ch = 8'd62;   // >
        7'd79:   ch = 8'd63;   // ?
        7'd80:   ch = 8'd64;   // @
        7'd81:   ch = 8'd91;   // [
        7'd82:   ch = 8'd93;   // ]
        7'd83:   ch = 8'd94;   // ^
        7'd84:   ch = 8'd95;   // _
        7'd85:   ch = 8'd96;   // backquote
        7'd86:   ch = 8'd123;  // {
        7'd87:   ch = 8'd124;  // |
        7'd88:   ch = 8'd125;  // }
        7'd89:   ch = 8'd126;  // ~
        7'd90:   ch = 8'd34;   // double quote
        default: ch = 8'd0;
      endcase
    end
    return ch;
  endfunction

endpackage

>>> hw/rtl/b91_front.sv
module b91_front import b91_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  b91_in_t  in_i,
  output logic     job_wr_o,
  output b91_job_t job_o
);

  logic [B91_QW-1:0]   bq_q, bq_d;
  logic [B91_CW-1:0]   cnt_q, cnt_d;
  logic [B91_SUMW-1:0] sum;
  logic [4:0]          n_all;
  logic [4:0]          n_rest;
  logic [B91_SUMW-1:0] rest;
  logic                take;
  logic                wide;

  // Append the byte above the held bits and split off a group
  always_comb begin
    sum    = {8'b0, bq_q} | ({13'b0, in_i.data_byte} << cnt_q);
    n_all  = {1'b0, cnt_q} + 5'd8;
    take   = n_all > 5'd13;
    wide   = sum[B91_QW-1:0] <= 13'(B91_WIDE_MAX);
    rest   = sum;
    n_rest = n_all;
    job_o.grp_vld = take;
    job_o.grp_val = wide ? sum[B91_GW-1:0] : {1'b0, sum[B91_QW-1:0]};
    if (take) begin
      if (wide) begin
        rest   = sum >> 14;
        n_rest = n_all - 5'd14;
      end else begin
        rest   = sum >> 13;
        n_rest = n_all - 5'd13;
      end
    end
    job_o.fl_vld = in_i.end_of_message && (n_rest != 5'd0);
    job_o.fl_val = rest[B91_QW-1:0];
    job_o.fl_two = (n_rest > 5'd7) || (rest[B91_QW-1:0] > 13'd90);
    job_o.eom    = in_i.end_of_message;
  end

  // Queue only bytes that produce characters
  assign job_wr_o = accept_i && (take || in_i.end_of_message);

  // Keep the remainder, or clear at the end of a message
  always_comb begin
    bq_d  = bq_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (in_i.end_of_message) begin
        bq_d  = '0;
        cnt_d = '0;
      end else begin
        bq_d  = rest[B91_QW-1:0];
        cnt_d = n_rest[B91_CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bq_q  <= '0;
      cnt_q <= '0;
    end else begin
      bq_q  <= bq_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/b91_fifo.sv
module b91_fifo import b91_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  b91_job_t wdata_i,
  input  logic     rd_i,
  output b91_job_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  b91_job_t        mem_q [Depth];
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/b91_back.sv
module b91_back import b91_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_avail_i,
  input  b91_job_t job_i,
  output logic     job_rd_o,
  input  logic     pop_i,
  output logic     empty_o,
  output b91_out_t out_o
);

  typedef enum logic [3:0] {
    ST_GRP_REM = 4'b0001,
    ST_GRP_QUO = 4'b0010,
    ST_FL_REM  = 4'b0100,
    ST_FL_QUO  = 4'b1000
  } b91_step_e;

  // Divide stage
  logic       div_vld_q;
  b91_job_t   div_job_q;
  logic [7:0] gq_q;
  logic [6:0] fq_q;
  logic [27:0] gprod;
  logic [26:0] fprod;
  logic        div_ld;

  // Emit stage
  b91_step_e   step_q, step_d;
  logic        out_vld_q;
  b91_out_t    out_q, out_d;
  logic        out_rdy;
  logic        emit;
  logic        final_step;
  logic [13:0] g_rem;
  logic [12:0] f_rem;
  logic [7:0]  g_hi;
  logic [6:0]  idx;

  assign out_rdy = !out_vld_q || pop_i;
  assign emit    = div_vld_q && out_rdy;

  // Last character of the current job
  always_comb begin
    if (div_job_q.fl_vld) begin
      final_step = div_job_q.fl_two ? (step_q == ST_FL_QUO) : (step_q == ST_FL_REM);
    end else begin
      final_step = step_q == ST_GRP_QUO;
    end
  end

  assign div_ld   = job_avail_i && (!div_vld_q || (emit && final_step));
  assign job_rd_o = div_ld;

  // Quotients by reciprocal multiply
  assign gprod = {14'b0, job_i.grp_val} * 28'(B91_RECIP);
  assign fprod = {14'b0, job_i.fl_val} * 27'(B91_RECIP);

  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_job_q <= job_i;
      gq_q      <= gprod[B91_RECIP_SHIFT +: 8];
      fq_q      <= fprod[B91_RECIP_SHIFT +: 7];
    end
  end

  // Remainders and the group quotient folded into the alphabet
  always_comb begin
    g_rem = div_job_q.grp_val - ({6'b0, gq_q} * 14'(B91_RADIX));
    f_rem = div_job_q.fl_val - ({6'b0, fq_q} * 13'(B91_RADIX));
    g_hi  = (gq_q >= 8'(B91_RADIX)) ? gq_q - 8'(B91_RADIX) : gq_q;
    case (step_q)
      ST_GRP_REM: idx = g_rem[6:0];
      ST_GRP_QUO: idx = g_hi[6:0];
      ST_FL_REM:  idx = f_rem[6:0];
      ST_FL_QUO:  idx = fq_q;
      default:    idx = '0;
    endcase
  end

  // Advance the step; restart on a newly loaded job
  always_comb begin
    step_d = step_q;
    if (div_ld) begin
      step_d = job_i.grp_vld ? ST_GRP_REM : ST_FL_REM;
    end else if (emit) begin
      case (step_q)
        ST_GRP_REM: step_d = ST_GRP_QUO;
        ST_GRP_QUO: step_d = ST_FL_REM;
        ST_FL_REM:  step_d = ST_FL_QUO;
        ST_FL_QUO:  step_d = ST_FL_QUO;
        default:    step_d = ST_GRP_REM;
      endcase
    end
  end

  // Output register
  always_comb begin
    out_d.out_char     = b91_char(idx);
    out_d.last_of_run  = final_step;
    out_d.message_done = final_step && div_job_q.eom;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= 1'b0;
      step_q    <= ST_GRP_REM;
      out_vld_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (div_ld) begin
        div_vld_q <= 1'b1;
      end else if (emit && final_step) begin
        div_vld_q <= 1'b0;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

endmodule

>>> hw/rtl/base91_stream_encoder.sv
// The first character of a byte passes the job queue, the divide register and the output register
// before it reaches the result ports. One byte per cycle in while the job queue has room; one
// character per cycle out while the consumer pops, set by the single character output register;
// a byte makes 0 to 2 characters, up to 4 on the final byte.
// Reset clears the bit queue, bit count, job queue pointers and output valid flag; no clearing pass.
module base91_stream_encoder import b91_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  b91_in_t  in_data_i,
  output logic     empty,
  input  logic     pop,
  output b91_out_t out_data_o
);

  logic     accept;
  logic     job_wr;
  b91_job_t job_w;
  b91_job_t job_r;
  logic     job_rd;
  logic     q_full;
  logic     q_empty;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Front: merge bytes into the bit queue and form jobs
  b91_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .job_wr_o (job_wr),
    .job_o    (job_w)
  );

  // Job queue between front and back
  b91_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_w),
    .rd_i    (job_rd),
    .rdata_o (job_r),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: divide, map to characters, deliver
  b91_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!q_empty),
    .job_i       (job_r),
    .job_rd_o    (job_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_data_o)
  );

endmodule
